FILE: hdl/lca_pkg.sv
// Shared definitions for the cellular automaton step unit.
// Grid limits, command codes, controller states and control bundles.
// No dependencies; imported by every module of the unit.
`default_nettype none

package lca_pkg;

   // Grid limits
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 7;
   localparam int CMD_W      = 2;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   // Command codes (code 3 is unused and only hands back a zero result)
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

   // Register indexes, taken from paddr[2]
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_FETCH,
      ST_WR_STORE,
      ST_RD_FETCH,
      ST_ADV_LAST,
      ST_ADV_FIRST,
      ST_ADV_SECOND,
      ST_ADV_SWEEP
   } state_type;

   // Row address sources for the grid memory read port
   typedef enum logic [2:0] {
      ADDR_REQ,
      ADDR_LAST,
      ADDR_FIRST,
      ADDR_SECOND,
      ADDR_AHEAD
   } addr_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         shift;
      logic         save_first;
      logic         cnt_clr;
      logic         sweep_wr;
      logic         cell_wr;
      logic         load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_row;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: hdl/lca_csr.sv
// Configuration registers of the cellular automaton step unit (APB-style).
// Holds grid width and height and hands out the clamped sizes in use.
// Depends on lca_pkg.
`default_nettype none

module lca_csr
   import lca_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output logic      [DIM_W-1:0]   width_used,
   output logic      [DIM_W-1:0]   height_used
);

   logic [DIM_W-1:0] grid_width_ff;
   logic [DIM_W-1:0] grid_height_ff;
   logic             wr_strobe;

   // Saturate a size to 3..max
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(3))
         r = DIM_W'(3);
      else if (v > maxv)
         r = maxv;
      else
         r = v;
      return r;
   endfunction

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= DIM_W'(MAX_WIDTH);
         grid_height_ff <= DIM_W'(MAX_HEIGHT);
      end else if (wr_strobe) begin
         if (paddr[2] == REG_GRID_WIDTH)
            grid_width_ff <= pwdata[DIM_W-1:0];
         else
            grid_height_ff <= pwdata[DIM_W-1:0];
      end
   end

   // Read-back of raw values
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_GRID_HEIGHT)
         prdata[DIM_W-1:0] = grid_height_ff;
      else
         prdata[DIM_W-1:0] = grid_width_ff;
   end

   assign width_used  = clamp_dim(grid_width_ff, DIM_W'(MAX_WIDTH));
   assign height_used = clamp_dim(grid_height_ff, DIM_W'(MAX_HEIGHT));

endmodule

`default_nettype wire

FILE: hdl/lca_dp.sv
// Datapath of the cellular automaton step unit: grid memory, row window,
// B3/S23 row update, row counter and result register.
// Depends on lca_pkg; driven by lca_ctrl.
`default_nettype none

module lca_dp
   import lca_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   output ctrl_status_type        status,
   input  wire logic [DIM_W-1:0]  width_used,
   input  wire logic [DIM_W-1:0]  height_used,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [COL_W-1:0]  req_col,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic              req_cell_value,
   output logic                   rsp_read_value
);

   // Grid memory, one row per entry, plus per-row valid bits
   logic [MAX_WIDTH-1:0]  grid_mem [MAX_HEIGHT];
   logic [MAX_HEIGHT-1:0] row_valid_ff;
   logic [MAX_WIDTH-1:0]  rd_ff;
   logic                  rd_vld_ff;

   // Latched item
   logic [CMD_W-1:0] cmd_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             val_ff;
   logic             inside_ff;

   // Row window
   logic [MAX_WIDTH-1:0] north_ff;
   logic [MAX_WIDTH-1:0] center_ff;
   logic [MAX_WIDTH-1:0] first_ff;
   logic [ROW_W-1:0]     cnt_ff;

   logic                 rsp_read_value_ff;
   logic                 rsp_read_value_in;

   logic [MAX_WIDTH-1:0] rdata;
   logic [MAX_WIDTH-1:0] south;
   logic [MAX_WIDTH-1:0] next_row;
   logic [MAX_WIDTH-1:0] merged_row;
   logic [MAX_WIDTH-1:0] wdata;
   logic [ROW_W-1:0]     raddr;
   logic [ROW_W-1:0]     waddr;
   logic                 we;
   logic [ROW_W-1:0]     h_last;
   logic [COL_W-1:0]     w_last;
   logic                 req_inside;

   assign h_last     = ROW_W'(height_used - DIM_W'(1));
   assign w_last     = COL_W'(width_used - DIM_W'(1));
   assign req_inside = ({1'b0, req_col} < width_used) && ({1'b0, req_row} < height_used);

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff    <= req_cmd;
         col_ff    <= req_col;
         row_ff    <= req_row;
         val_ff    <= req_cell_value;
         inside_ff <= req_inside;
      end
   end

   // Read address select
   always_comb begin
      case (cmd.rd_sel)
         ADDR_REQ:    raddr = row_ff;
         ADDR_LAST:   raddr = h_last;
         ADDR_FIRST:  raddr = '0;
         ADDR_SECOND: raddr = ROW_W'(1);
         ADDR_AHEAD:  raddr = cnt_ff + ROW_W'(2);
         default:     raddr = row_ff;
      endcase
   end

   // Never-written rows read as dead
   assign rdata = rd_vld_ff ? rd_ff : '0;

   // Cell write merges into the fetched row
   always_comb begin
      merged_row         = rdata;
      merged_row[col_ff] = val_ff;
   end

   assign we    = cmd.sweep_wr || (cmd.cell_wr && inside_ff);
   assign waddr = cmd.sweep_wr ? cnt_ff : row_ff;
   assign wdata = cmd.sweep_wr ? next_row : merged_row;

   // Grid memory
   always_ff @(posedge clock) begin
      if (we)
         grid_mem[waddr] <= wdata;
      if (cmd.rd_en)
         rd_ff <= grid_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (we)
            row_valid_ff[waddr] <= 1'b1;
         if (cmd.rd_en)
            rd_vld_ff <= row_valid_ff[raddr];
      end
   end

   // Row window and saved first row
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         north_ff  <= center_ff;
         center_ff <= rdata;
      end
      if (cmd.save_first)
         first_ff <= rdata;
   end

   // Row counter
   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= '0;
      else if (cmd.cnt_clr)
         cnt_ff <= '0;
      else if (cmd.sweep_wr)
         cnt_ff <= cnt_ff + ROW_W'(1);
   end

   assign status.last_row = (cnt_ff == h_last);

   // Bottom row wraps to the original first row
   assign south = status.last_row ? first_ff : rdata;

   // B3/S23 update of one row, columns wrap at the width in use
   always_comb begin
      logic [COL_W-1:0] wi;
      logic [COL_W-1:0] ei;
      logic [3:0]       n;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         wi = (c == 0) ? w_last : COL_W'(c - 1);
         ei = (COL_W'(c) == w_last) ? '0 : COL_W'(c + 1);
         n  = {3'b0, north_ff[wi]} + {3'b0, north_ff[c]} + {3'b0, north_ff[ei]}
            + {3'b0, center_ff[wi]} + {3'b0, center_ff[ei]}
            + {3'b0, south[wi]} + {3'b0, south[c]} + {3'b0, south[ei]};
         if (DIM_W'(c) < width_used)
            next_row[c] = (n == 4'd3) || (center_ff[c] && (n == 4'd2));
         else
            next_row[c] = center_ff[c];
      end
   end

   // Result register
   assign rsp_read_value_in = (cmd_ff == CMD_READ) && inside_ff && rdata[col_ff];

   always_ff @(posedge clock) begin
      if (cmd.load_rsp)
         rsp_read_value_ff <= rsp_read_value_in;
   end

   assign rsp_read_value = rsp_read_value_ff;

   // Sweep never reads the row it is writing
   a_sweep_no_collision: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_wr && cmd.rd_en) |-> (raddr != waddr))
      else $error("sweep read and write hit the same row");

endmodule

`default_nettype wire

FILE: hdl/lca_ctrl.sv
// Controller of the cellular automaton step unit: sequences cell access,
// the generation sweep and the result hand-off.
// Depends on lca_pkg; drives lca_dp.
`default_nettype none

module lca_ctrl
   import lca_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ctrl_cmd_type          cmd,
   input  wire ctrl_status_type  status
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      finish_ff;
   logic      finish_in;
   logic      accept;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE) || finish_ff;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      case (state_ff)
         ST_IDLE: begin
            if (finish_ff) begin
               if (slot_free)
                  finish_in = 1'b0;
            end else if (accept) begin
               case (req_cmd)
                  CMD_WRITE:   state_in = ST_WR_FETCH;
                  CMD_READ:    state_in = ST_RD_FETCH;
                  CMD_ADVANCE: state_in = ST_ADV_LAST;
                  default:     finish_in = 1'b1;
               endcase
            end
         end
         ST_WR_FETCH:   state_in = ST_WR_STORE;
         ST_WR_STORE: begin
            state_in  = ST_IDLE;
            finish_in = 1'b1;
         end
         ST_RD_FETCH: begin
            state_in  = ST_IDLE;
            finish_in = 1'b1;
         end
         ST_ADV_LAST:   state_in = ST_ADV_FIRST;
         ST_ADV_FIRST:  state_in = ST_ADV_SECOND;
         ST_ADV_SECOND: state_in = ST_ADV_SWEEP;
         ST_ADV_SWEEP: begin
            if (status.last_row) begin
               state_in  = ST_IDLE;
               finish_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd        = '0;
      cmd.rd_sel = ADDR_REQ;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch_req = accept;
            cmd.load_rsp  = finish_ff && slot_free;
         end
         ST_WR_FETCH: cmd.rd_en   = 1'b1;
         ST_WR_STORE: cmd.cell_wr = 1'b1;
         ST_RD_FETCH: cmd.rd_en   = 1'b1;
         ST_ADV_LAST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ADDR_LAST;
         end
         ST_ADV_FIRST: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ADDR_FIRST;
            cmd.shift  = 1'b1;
         end
         ST_ADV_SECOND: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = ADDR_SECOND;
            cmd.shift      = 1'b1;
            cmd.save_first = 1'b1;
            cmd.cnt_clr    = 1'b1;
         end
         ST_ADV_SWEEP: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = ADDR_AHEAD;
            cmd.shift    = 1'b1;
            cmd.sweep_wr = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   // Output valid: set on hand-off, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      if (cmd.load_rsp)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff != ST_IDLE) || finish_ff))
      else $error("accepted item did not start");

   a_sweep_end_finishes: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_wr && status.last_row) |=> (finish_ff && (state_ff == ST_IDLE)))
      else $error("sweep end did not reach result hand-off");

   a_rsp_rise_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish_ff))
      else $error("result appeared without a finished item");

endmodule

`default_nettype wire

FILE: hdl/life_cellular_automaton_step_unit.sv
// Top level of the cellular automaton step unit (B3/S23 on a torus).
// Instantiates lca_csr, lca_ctrl and lca_dp; depends on lca_pkg.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  req_cmd, req_col, req_row, req_cell_value
//   rsp_     out        rsp_valid / rsp_stall  rsp_read_value
//   APB      in/out     psel, penable, pready  paddr, pwdata, prdata
//
// A read fetches the row and then hands off the result; a cell write fetches
// the row, then merges and stores the whole row; an advance does three row
// prefetches, one row per cycle through the memory's read and write ports,
// then the result hand-off. Unused commands go straight to the hand-off.
// Reset is synchronous; the grid reads dead through per-row valid bits.
// A stalled result sits in the output register while the next item starts.
`default_nettype none

module life_cellular_automaton_step_unit
   import lca_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [COL_W-1:0]   req_col,
   input  wire logic [ROW_W-1:0]   req_row,
   input  wire logic               req_cell_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_read_value,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   logic [DIM_W-1:0] width_used;
   logic [DIM_W-1:0] height_used;
   ctrl_cmd_type     ctrl_cmd;
   ctrl_status_type  ctrl_status;

   lca_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .width_used  (width_used),
      .height_used (height_used)
   );

   lca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (ctrl_cmd),
      .status    (ctrl_status)
   );

   lca_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .status         (ctrl_status),
      .width_used     (width_used),
      .height_used    (height_used),
      .req_cmd        (req_cmd),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_cell_value (req_cell_value),
      .rsp_read_value (rsp_read_value)
   );

endmodule

`default_nettype wire

FILE: tb/life_cellular_automaton_step_unit_tb.sv
// Self-checking testbench for the B3/S23 torus step unit: drives cell writes, reads and
// generation steps with random idling, and checks every result against a grid predictor.
// Depends on lca_pkg and life_cellular_automaton_step_unit.
`timescale 1ns / 100ps

import lca_pkg::*;

// Grid predictor and store of pending read values
class life_grid_scoreboard;
   bit [MAX_WIDTH-1:0] cells [MAX_HEIGHT];
   bit [DIM_W-1:0]     width_reg;
   bit [DIM_W-1:0]     height_reg;
   bit                 pending_reads [$];
   int unsigned        failures;
   int unsigned        transfers_in;
   int unsigned        transfers_out;
   int unsigned        generations;

   function new();
      foreach (cells[r]) cells[r] = '0;
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
   endfunction

   // register values outside 3..max saturate
   function int unsigned clamp_dim(bit [DIM_W-1:0] v, int unsigned top);
      if (v < 3) return 3;
      if (v > top) return top;
      return 32'(v);
   endfunction

   function int unsigned used_width();
      return clamp_dim(width_reg, MAX_WIDTH);
   endfunction

   function int unsigned used_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
   endfunction

   function void write_register(logic index, bit [DIM_W-1:0] value);
      if (index == REG_GRID_WIDTH) width_reg = value;
      else height_reg = value;
   endfunction

   // one generation over the active window, wrapping at its edges;
   // cells outside the window keep their values
   function void step_generation();
      bit [MAX_WIDTH-1:0] upcoming [MAX_HEIGHT];
      int unsigned w, h, rn, rs, cw, ce, n;
      w = used_width();
      h = used_height();
      upcoming = cells;
      for (int unsigned r = 0; r < h; r++) begin
         rn = (r + h - 1) % h;
         rs = (r + 1) % h;
         for (int unsigned c = 0; c < w; c++) begin
            cw = (c + w - 1) % w;
            ce = (c + 1) % w;
            n = $countones({cells[rn][cw], cells[rn][c], cells[rn][ce], cells[r][cw],
                            cells[r][ce], cells[rs][cw], cells[rs][c], cells[rs][ce]});
            upcoming[r][c] = cells[r][c] ? (n == 2 || n == 3) : (n == 3);
         end
      end
      cells = upcoming;
   endfunction

   // note one accepted request transfer and queue its read value
   function void apply_request(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row, logic val);
      bit in_grid;
      bit value_out;
      in_grid = (col < used_width()) && (row < used_height());
      value_out = 1'b0;
      transfers_in++;
      case (cmd)
         CMD_WRITE: if (in_grid) cells[row][col] = val;
         CMD_READ: if (in_grid) value_out = cells[row][col];
         CMD_ADVANCE: begin
            step_generation();
            generations++;
         end
         default: ;
      endcase
      pending_reads.push_back(value_out);
   endfunction

   // check one accepted result transfer against the oldest pending value
   function void compare_read_value(logic got);
      bit want;
      transfers_out++;
      if (pending_reads.size() == 0) begin
         $error("rsp_read_value: no result pending, actual %0b", got);
         failures++;
         return;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
         $error("rsp_read_value: expected %0b, actual %0b", want, got);
         failures++;
      end
   endfunction

   function void report_leftovers();
      if (pending_reads.size() != 0) begin
         $error("rsp_read_value: %0d results never arrived", pending_reads.size());
         failures++;
      end
   endfunction
endclass

module life_cellular_automaton_step_unit_tb;

   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
   localparam int               STUCK_LIMIT = 3000;
   localparam int               ITEM_TARGET = 1230;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd = CMD_WRITE;
   logic [COL_W-1:0]   req_col = '0;
   logic [ROW_W-1:0]   req_row = '0;
   logic               req_cell_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_read_value;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   life_grid_scoreboard sb;
   bit                  quiet = 1'b0;
   int unsigned         stuck_cycles = 0;
   int unsigned         phase_count = 0;

   life_cellular_automaton_step_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitors feed the scoreboard
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.apply_request(req_cmd, req_col, req_row, req_cell_value);
      if (!reset && rsp_valid && !rsp_stall)
         sb.compare_read_value(rsp_read_value);
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= !quiet && !reset && ($urandom_range(0, 99) < 22);
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one item, with an optional idle gap, and hold it until the transfer
   task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned col,
                            input int unsigned row, input bit val);
      if (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_col        <= col[COL_W-1:0];
      req_row        <= row[ROW_W-1:0];
      req_cell_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mostly a cell inside the active window (often near the origin), sometimes noise
   task automatic send_shaped(input logic [CMD_W-1:0] cmd, input bit val);
      int unsigned w, h;
      w = sb.used_width();
      h = sb.used_height();
      if ($urandom_range(0, 99) < 12) begin
         send_item(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                   $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      end else begin
         if ($urandom_range(0, 1)) begin
            if (w > 8) w = 8;
            if (h > 8) h = 8;
         end
         send_item(cmd, $urandom_range(0, w - 1), $urandom_range(0, h - 1), val);
      end
   endtask

   // stop sending and let every pending result arrive
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup then access phase; upper data bits carry junk
   task automatic csr_write(input logic index, input logic [DIM_W-1:0] value);
      logic [PDATA_W-1:0] upper;
      upper = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {upper[PDATA_W-1:DIM_W], value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_register(index, value);
   endtask

   // mostly small grids, with the extremes and saturating values mixed in
   function automatic logic [DIM_W-1:0] pick_dim();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 8) return DIM_W'($urandom_range(0, 2));
      if (k < 16) return DIM_W'($urandom_range(65, 127));
      if (k < 24) return DIM_W'(64);
      if (k < 36) return DIM_W'(3);
      return DIM_W'($urandom_range(4, 12));
   endfunction

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // full 64x64 grid out of reset: dead read, corners that touch across the wrap
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_WRITE, 63, 63, 1);
      send_item(CMD_WRITE, 0, 0, 1);
      send_item(CMD_WRITE, 63, 0, 1);
      send_item(CMD_WRITE, 0, 63, 1);
      send_item(CMD_READ, 63, 63, 0);
      send_item(CMD_UNUSED, 63, 63, 1);
      send_item(CMD_ADVANCE, 0, 0, 0);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_READ, 63, 0, 0);
      send_item(CMD_WRITE, 0, 0, 0);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_WRITE, 40, 40, 1);
      wait_for_results();

      // saturating sizes: width 0 acts as 3, height 127 as 64
      csr_write(REG_GRID_WIDTH, DIM_W'(0));
      csr_write(REG_GRID_HEIGHT, DIM_W'(127));
      send_item(CMD_WRITE, 3, 5, 1);
      send_item(CMD_READ, 3, 5, 0);
      send_item(CMD_WRITE, 0, 5, 1);
      send_item(CMD_WRITE, 1, 5, 1);
      send_item(CMD_WRITE, 2, 5, 1);
      send_item(CMD_ADVANCE, 0, 0, 0);
      send_item(CMD_READ, 1, 4, 0);
      send_item(CMD_READ, 1, 6, 0);
      send_item(CMD_READ, 40, 40, 0);
      wait_for_results();

      // enlarged again: the cell kept outside the window must reappear
      csr_write(REG_GRID_WIDTH, DIM_W'(64));
      csr_write(REG_GRID_HEIGHT, DIM_W'(64));
      send_item(CMD_READ, 40, 40, 0);

      // random phases: seed a pattern, then step and probe it
      while (sb.transfers_in < ITEM_TARGET) begin
         wait_for_results();
         quiet = (phase_count == 2);
         csr_write(REG_GRID_WIDTH, pick_dim());
         csr_write(REG_GRID_HEIGHT, pick_dim());
         repeat ($urandom_range(6, 30)) send_shaped(CMD_WRITE, $urandom_range(0, 99) < 70);
         repeat ($urandom_range(2, 5)) begin
            send_shaped(CMD_ADVANCE, 1'b0);
            repeat ($urandom_range(3, 10))
               send_shaped(($urandom_range(0, 99) < 15) ? CMD_WRITE : CMD_READ,
                           1'($urandom_range(0, 1)));
         end
         phase_count++;
      end
      quiet = 1'b0;

      wait_for_results();
      repeat (10) @(posedge clock);
      sb.report_leftovers();
      $display("Run covered %0d request transfers, %0d results, %0d generation steps,",
               sb.transfers_in, sb.transfers_out, sb.generations);
      $display("over %0d random grid shapes plus the directed wrap and saturation cases.",
               phase_count);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
